### design/mfhp_pkg.sv
// Shared types and constants for the music file header parser.
`default_nettype none

package mfhp_pkg;

    typedef enum logic [2:0] {
        PH_TITLE,
        PH_NAME,
        PH_OFFS,
        PH_WAIT,
        PH_DONE
    } t_phase;

    // result kinds
    localparam logic [2:0] KIND_TITLE_BYTE = 3'd0;
    localparam logic [2:0] KIND_TITLE_END  = 3'd1;
    localparam logic [2:0] KIND_NAME_BYTE  = 3'd2;
    localparam logic [2:0] KIND_NAME_END   = 3'd3;
    localparam logic [2:0] KIND_VOICE_OFFS = 3'd4;
    localparam logic [2:0] KIND_TRACK_OFFS = 3'd5;
    localparam logic [2:0] KIND_MODE       = 3'd6;
    localparam logic [2:0] KIND_ERROR      = 3'd7;

    // error causes, carried in the index field
    localparam logic [7:0] ERR_TRUNCATED = 8'd0;
    localparam logic [7:0] ERR_FAR       = 8'd1;
    localparam logic [7:0] ERR_IN_HEADER = 8'd2;

    // configuration register indexes
    localparam logic REG_FILE_LENGTH = 1'b0;
    localparam logic REG_PCM8_OPCODE = 1'b1;

    localparam logic [7:0]  PCM8_RESET   = 8'd232;
    localparam logic [15:0] TITLE_CRLF   = 16'h0D0A;
    localparam logic [7:0]  TITLE_EOF    = 8'h1A;
    localparam logic [7:0]  NAME_END     = 8'h00;
    localparam logic [31:0] PDX_SUFFIX   = 32'h2E706478;
    localparam logic [5:0]  HEADER_BYTES = 6'd34;
    localparam logic [23:0] MAX24        = 24'hFFFFFF;
    localparam logic [4:0]  TRACKS_PCM8  = 5'd16;
    localparam logic [4:0]  TRACKS_STD   = 5'd9;
    localparam logic [15:0] USED_PCM8    = 16'hFFFF;
    localparam logic [15:0] USED_STD     = 16'h01FF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  index;
        logic [23:0] value;
        logic        flag;
        logic [4:0]  aux;
        logic        last_of_run;
    } t_result;

endpackage

`default_nettype wire

### design/music_file_header_parser_core.sv
// Top level of the music file header parser: byte parser, result queue and register port.
`default_nettype none

//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_data_byte, i_last_byte
//  output    out        o_out_valid / i_out_stall o_kind, o_index, o_value, o_flag,
//                                                 o_aux, o_last_of_run
//  config    APB        psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One byte is parsed per cycle unless the input stalls: the state update and its results are
// formed in the cycle the beat is accepted and pushed into a four-entry result queue.
// A byte yields up to two results, so it can occupy the output for two beats; the
// input stalls whenever fewer than two queue entries are free.
// Reset is synchronous and clears the parser state, the queue and the registers.
// After the mode result or an error, bytes are still taken but give nothing until reset.

module music_file_header_parser_core #(
    parameter int TITLE_LEN = 256,
    parameter int NAME_LEN  = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_index,
    output logic [23:0]      o_value,
    output logic             o_flag,
    output logic [4:0]       o_aux,
    output logic             o_last_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [7:0] TITLE_MAX = 8'(TITLE_LEN - 1);
    localparam logic [7:0] NAME_MAX  = 8'(NAME_LEN - 1);

    // configuration
    logic [23:0] r_file_length;
    logic [7:0]  r_pcm8_opcode;
    logic        cfg_wr;

    // parser state
    mfhp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_title_window, n_title_window;
    logic [1:0]  r_window_fill, n_window_fill;
    logic [7:0]  r_title_pos, n_title_pos;
    logic [7:0]  r_name_pos, n_name_pos;
    logic [31:0] r_suffix_window, n_suffix_window;
    logic        r_name_seen, n_name_seen;
    logic [23:0] r_stream_pos, n_stream_pos;
    logic [23:0] r_base_pos, n_base_pos;
    logic [24:0] r_header_end, n_header_end;
    logic [5:0]  r_offset_count, n_offset_count;
    logic [7:0]  r_high_byte, n_high_byte;
    logic [23:0] r_first_track, n_first_track;
    logic [15:0] r_far_mask, n_far_mask;

    // result queue
    mfhp_pkg::t_result r_queue [4];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;

    logic in_accept, out_accept;
    logic [24:0] abs_sum;
    logic [23:0] abs_sat;
    logic        abs_far;
    logic [3:0]  track;
    logic        is_pcm8;
    logic [7:0]  low_byte;
    mfhp_pkg::t_result prim, err, slot0, slot1;
    logic prim_v, err_v;
    logic [1:0] n_results;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    assign in_accept  = i_in_valid & ~o_in_stall;
    assign out_accept = o_out_valid & ~i_out_stall;
    assign o_in_stall = (r_count >= 3'd3);

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == mfhp_pkg::REG_PCM8_OPCODE) ? {24'd0, r_pcm8_opcode}
                                                            : {8'd0, r_file_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_pcm8_opcode <= mfhp_pkg::PCM8_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == mfhp_pkg::REG_FILE_LENGTH) begin
                r_file_length <= pwdata[23:0];
            end else begin
                r_pcm8_opcode <= pwdata[7:0];
            end
        end
    end

    // offset arithmetic
    assign abs_sum  = {9'd0, r_high_byte, i_data_byte} + {1'b0, r_base_pos};
    assign abs_sat  = abs_sum[24] ? mfhp_pkg::MAX24 : abs_sum[23:0];
    assign abs_far  = abs_sum > {1'b0, r_file_length};
    assign track    = 4'(r_offset_count[5:1] - 5'd1);
    assign is_pcm8  = (i_data_byte == r_pcm8_opcode);
    assign low_byte = to_lower(i_data_byte);

    always_comb begin
        n_phase         = r_phase;
        n_title_window  = r_title_window;
        n_window_fill   = r_window_fill;
        n_title_pos     = r_title_pos;
        n_name_pos      = r_name_pos;
        n_suffix_window = r_suffix_window;
        n_name_seen     = r_name_seen;
        n_stream_pos    = r_stream_pos;
        n_base_pos      = r_base_pos;
        n_header_end    = r_header_end;
        n_offset_count  = r_offset_count;
        n_high_byte     = r_high_byte;
        n_first_track   = r_first_track;
        n_far_mask      = r_far_mask;
        prim   = '0;
        err    = '0;
        prim_v = 1'b0;
        err_v  = 1'b0;
        err.kind  = mfhp_pkg::KIND_ERROR;
        err.value = r_stream_pos;

        case (r_phase)
            mfhp_pkg::PH_TITLE: begin
                if (r_window_fill >= 2'd2 && r_title_window == mfhp_pkg::TITLE_CRLF
                        && i_data_byte == mfhp_pkg::TITLE_EOF) begin
                    prim_v     = 1'b1;
                    prim.kind  = mfhp_pkg::KIND_TITLE_END;
                    prim.index = r_title_pos;
                    n_phase    = mfhp_pkg::PH_NAME;
                end else begin
                    // two bytes held back so the terminator never shows as text
                    if (r_window_fill >= 2'd2) begin
                        prim_v     = 1'b1;
                        prim.kind  = mfhp_pkg::KIND_TITLE_BYTE;
                        prim.index = r_title_pos;
                        prim.value = {16'd0, r_title_window[15:8]};
                        if (r_title_pos < TITLE_MAX) begin
                            n_title_pos = r_title_pos + 8'd1;
                        end
                    end else begin
                        n_window_fill = r_window_fill + 2'd1;
                    end
                    n_title_window = {r_title_window[7:0], i_data_byte};
                end
            end
            mfhp_pkg::PH_NAME: begin
                prim_v     = 1'b1;
                prim.index = r_name_pos;
                if (i_data_byte == mfhp_pkg::NAME_END) begin
                    prim.kind = mfhp_pkg::KIND_NAME_END;
                    prim.flag = r_name_seen;
                    prim.aux  = {4'd0, r_name_seen
                                 & (r_suffix_window != mfhp_pkg::PDX_SUFFIX)};
                    if (r_stream_pos != mfhp_pkg::MAX24) begin
                        n_base_pos   = r_stream_pos + 24'd1;
                        n_header_end = {1'b0, r_stream_pos}
                                       + 25'({1'b0, mfhp_pkg::HEADER_BYTES}) + 25'd1;
                    end else begin
                        n_base_pos   = mfhp_pkg::MAX24;
                        n_header_end = {1'b0, mfhp_pkg::MAX24}
                                       + 25'({1'b0, mfhp_pkg::HEADER_BYTES});
                    end
                    n_phase = mfhp_pkg::PH_OFFS;
                end else begin
                    n_name_seen = 1'b1;
                    prim.kind   = mfhp_pkg::KIND_NAME_BYTE;
                    prim.value  = {16'd0, i_data_byte};
                    if (r_name_pos < NAME_MAX) begin
                        n_name_pos = r_name_pos + 8'd1;
                    end
                    n_suffix_window = {r_suffix_window[23:0], low_byte};
                end
            end
            mfhp_pkg::PH_OFFS: begin
                if (!r_offset_count[0]) begin
                    n_high_byte = i_data_byte;
                end else begin
                    prim_v     = 1'b1;
                    prim.value = abs_sat;
                    prim.flag  = abs_far;
                    if (r_offset_count[5:1] == 5'd0) begin
                        prim.kind = mfhp_pkg::KIND_VOICE_OFFS;
                        if (abs_far) begin
                            err_v     = 1'b1;
                            err.index = mfhp_pkg::ERR_FAR;
                            n_phase   = mfhp_pkg::PH_DONE;
                        end
                    end else begin
                        prim.kind  = mfhp_pkg::KIND_TRACK_OFFS;
                        prim.index = {4'd0, track};
                        if (abs_far) begin
                            n_far_mask = r_far_mask | (16'd1 << track);
                        end
                        if (track == 4'd0) begin
                            n_first_track = abs_sat;
                            if (abs_far) begin
                                err_v     = 1'b1;
                                err.index = mfhp_pkg::ERR_FAR;
                                n_phase   = mfhp_pkg::PH_DONE;
                            end else if ({1'b0, abs_sat} < r_header_end) begin
                                // track data would start inside the header itself
                                err_v     = 1'b1;
                                err.index = mfhp_pkg::ERR_IN_HEADER;
                                n_phase   = mfhp_pkg::PH_DONE;
                            end
                        end
                    end
                end
                n_offset_count = r_offset_count + 6'd1;
                if (n_phase == mfhp_pkg::PH_OFFS
                        && n_offset_count >= mfhp_pkg::HEADER_BYTES) begin
                    n_phase = mfhp_pkg::PH_WAIT;
                end
            end
            mfhp_pkg::PH_WAIT: begin
                if (r_stream_pos == r_first_track) begin
                    prim_v     = 1'b1;
                    prim.kind  = mfhp_pkg::KIND_MODE;
                    prim.value = {16'd0, i_data_byte};
                    prim.flag  = is_pcm8;
                    prim.aux   = is_pcm8 ? mfhp_pkg::TRACKS_PCM8 : mfhp_pkg::TRACKS_STD;
                    if ((r_far_mask & (is_pcm8 ? mfhp_pkg::USED_PCM8
                                               : mfhp_pkg::USED_STD)) != 16'd0) begin
                        err_v     = 1'b1;
                        err.index = mfhp_pkg::ERR_FAR;
                    end
                    n_phase = mfhp_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (r_phase != mfhp_pkg::PH_DONE) begin
            if (i_last_byte && n_phase != mfhp_pkg::PH_DONE) begin
                err_v     = 1'b1;
                err.index = mfhp_pkg::ERR_TRUNCATED;
                n_phase   = mfhp_pkg::PH_DONE;
            end
            if (r_stream_pos != mfhp_pkg::MAX24) begin
                n_stream_pos = r_stream_pos + 24'd1;
            end
        end

        slot0 = prim_v ? prim : err;
        slot1 = err;
        slot0.last_of_run = ~(prim_v & err_v);
        slot1.last_of_run = 1'b1;
        n_results = {1'b0, prim_v} + {1'b0, err_v};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= mfhp_pkg::PH_TITLE;
            r_title_window  <= '0;
            r_window_fill   <= '0;
            r_title_pos     <= '0;
            r_name_pos      <= '0;
            r_suffix_window <= '0;
            r_name_seen     <= 1'b0;
            r_stream_pos    <= '0;
            r_base_pos      <= '0;
            r_header_end    <= '0;
            r_offset_count  <= '0;
            r_high_byte     <= '0;
            r_first_track   <= '0;
            r_far_mask      <= '0;
        end else if (in_accept) begin
            r_phase         <= n_phase;
            r_title_window  <= n_title_window;
            r_window_fill   <= n_window_fill;
            r_title_pos     <= n_title_pos;
            r_name_pos      <= n_name_pos;
            r_suffix_window <= n_suffix_window;
            r_name_seen     <= n_name_seen;
            r_stream_pos    <= n_stream_pos;
            r_base_pos      <= n_base_pos;
            r_header_end    <= n_header_end;
            r_offset_count  <= n_offset_count;
            r_high_byte     <= n_high_byte;
            r_first_track   <= n_first_track;
            r_far_mask      <= n_far_mask;
        end
    end

    // result queue: up to two entries pushed per beat, one popped
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (n_results != 2'd0) begin
                r_queue[r_wr_ptr] <= slot0;
            end
            if (n_results == 2'd2) begin
                r_queue[r_wr_ptr + 2'd1] <= slot1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= r_wr_ptr + n_results;
            end
            if (out_accept) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (in_accept ? {1'b0, n_results} : 3'd0)
                       - {2'd0, out_accept};
        end
    end

    assign o_out_valid   = (r_count != 3'd0);
    assign o_kind        = r_queue[r_rd_ptr].kind;
    assign o_index       = r_queue[r_rd_ptr].index;
    assign o_value       = r_queue[r_rd_ptr].value;
    assign o_flag        = r_queue[r_rd_ptr].flag;
    assign o_aux         = r_queue[r_rd_ptr].aux;
    assign o_last_of_run = r_queue[r_rd_ptr].last_of_run;

endmodule

`default_nettype wire

### tb/music_file_header_parser_core_tb.sv
// Self-checking testbench for the music file header parser core.
module music_file_header_parser_core_tb;

    localparam int TITLE_LEN = 256;
    localparam int NAME_LEN  = 64;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire [2:0]   o_kind;
    wire [7:0]   o_index;
    wire [23:0]  o_value;
    wire         o_flag;
    wire [4:0]   o_aux;
    wire         o_last_of_run;
    wire [31:0]  prdata;
    wire         pready;

    music_file_header_parser_core #(
        .TITLE_LEN(TITLE_LEN),
        .NAME_LEN (NAME_LEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_index      (o_index),
        .o_value      (o_value),
        .o_flag       (o_flag),
        .o_aux        (o_aux),
        .o_last_of_run(o_last_of_run),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state as predicted, plus the register copies
    mfhp_pkg::t_phase ph = mfhp_pkg::PH_TITLE;
    logic [15:0] title_window = '0;
    logic [1:0]  window_fill = '0;
    logic [7:0]  title_pos = '0;
    logic [7:0]  name_pos = '0;
    logic [31:0] suffix_window = '0;
    logic        name_seen = 1'b0;
    logic [23:0] stream_pos = '0;
    logic [23:0] base_pos = '0;
    logic [5:0]  offset_byte_count = '0;
    logic [7:0]  high_byte_hold = '0;
    logic [23:0] first_track_offset = '0;
    logic [15:0] far_mask = '0;
    logic [23:0] cfg_file_length = '0;
    logic [7:0]  cfg_opcode = mfhp_pkg::PCM8_RESET;

    mfhp_pkg::t_result expected_results[$];
    t_file_byte file_bytes[$];
    int         mismatch_count = 0;
    int         byte_count = 0;
    int         trunc_at = -1;
    bit         in_taken = 1'b0;
    int         idle_mode = 0;
    int         cycle_count = 0;
    int         send_gap_pct[4] = '{0, 74, 0, 36};
    int         stall_pct[4] = '{0, 0, 74, 36};

    function automatic mfhp_pkg::t_result make_result(input logic [2:0] k,
                                                      input logic [7:0] idx,
                                                      input logic [23:0] val, input logic f,
                                                      input logic [4:0] a);
        mfhp_pkg::t_result r;
        r.kind = k;
        r.index = idx;
        r.value = val;
        r.flag = f;
        r.aux = a;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Advance the header parser by one file byte and queue the results it gives.
    task automatic parse_byte(input logic [7:0] b, input logic lst);
        mfhp_pkg::t_result res[$];
        mfhp_pkg::t_result r;
        logic [23:0] pos;
        logic [24:0] offs_sum;
        logic [25:0] hdr_end;
        logic [23:0] offs;
        logic        far;
        logic        pcm;
        logic        has_sfx;
        logic [4:0]  pair;
        logic [3:0]  trk;
        int          j;
        pos = stream_pos;
        if (ph == mfhp_pkg::PH_DONE)
            return;
        case (ph)
            mfhp_pkg::PH_TITLE: begin
                if (window_fill >= 2'd2 && title_window == mfhp_pkg::TITLE_CRLF
                        && b == mfhp_pkg::TITLE_EOF) begin
                    res.push_back(make_result(mfhp_pkg::KIND_TITLE_END, title_pos, '0,
                                              1'b0, '0));
                    ph = mfhp_pkg::PH_NAME;
                end else begin
                    if (window_fill >= 2'd2) begin
                        res.push_back(make_result(mfhp_pkg::KIND_TITLE_BYTE, title_pos,
                                                  {16'h0, title_window[15:8]}, 1'b0, '0));
                        if (title_pos < TITLE_LEN - 1)
                            title_pos++;
                    end else begin
                        window_fill++;
                    end
                    title_window = {title_window[7:0], b};
                end
            end
            mfhp_pkg::PH_NAME: begin
                if (b == mfhp_pkg::NAME_END) begin
                    has_sfx = (suffix_window == mfhp_pkg::PDX_SUFFIX);
                    res.push_back(make_result(mfhp_pkg::KIND_NAME_END, name_pos, '0,
                                              name_seen, {4'b0, name_seen && !has_sfx}));
                    base_pos = (pos < mfhp_pkg::MAX24) ? pos + 24'd1 : mfhp_pkg::MAX24;
                    ph = mfhp_pkg::PH_OFFS;
                end else begin
                    name_seen = 1'b1;
                    res.push_back(make_result(mfhp_pkg::KIND_NAME_BYTE, name_pos,
                                              {16'h0, b}, 1'b0, '0));
                    if (name_pos < NAME_LEN - 1)
                        name_pos++;
                    suffix_window = {suffix_window[23:0],
                                     (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b};
                end
            end
            mfhp_pkg::PH_OFFS: begin
                if (!offset_byte_count[0]) begin
                    high_byte_hold = b;
                end else begin
                    pair = offset_byte_count[5:1];
                    offs_sum = {9'd0, high_byte_hold, b} + {1'b0, base_pos};
                    far = (offs_sum > {1'b0, cfg_file_length});
                    offs = offs_sum[24] ? mfhp_pkg::MAX24 : offs_sum[23:0];
                    if (pair == 5'd0) begin
                        res.push_back(make_result(mfhp_pkg::KIND_VOICE_OFFS, '0, offs,
                                                  far, '0));
                        if (far) begin
                            res.push_back(make_result(mfhp_pkg::KIND_ERROR,
                                                      mfhp_pkg::ERR_FAR, pos, 1'b0, '0));
                            ph = mfhp_pkg::PH_DONE;
                        end
                    end else begin
                        trk = 4'(pair - 5'd1);
                        res.push_back(make_result(mfhp_pkg::KIND_TRACK_OFFS, {4'b0, trk},
                                                  offs, far, '0));
                        if (far)
                            far_mask[trk] = 1'b1;
                        if (trk == 4'd0) begin
                            first_track_offset = offs;
                            hdr_end = {2'b0, base_pos} + 26'(mfhp_pkg::HEADER_BYTES);
                            if (far) begin
                                res.push_back(make_result(mfhp_pkg::KIND_ERROR,
                                                          mfhp_pkg::ERR_FAR, pos, 1'b0, '0));
                                ph = mfhp_pkg::PH_DONE;
                            end else if ({1'b0, offs_sum} < hdr_end) begin
                                res.push_back(make_result(mfhp_pkg::KIND_ERROR,
                                                          mfhp_pkg::ERR_IN_HEADER, pos,
                                                          1'b0, '0));
                                ph = mfhp_pkg::PH_DONE;
                            end
                        end
                    end
                end
                offset_byte_count++;
                if (ph == mfhp_pkg::PH_OFFS && offset_byte_count >= mfhp_pkg::HEADER_BYTES)
                    ph = mfhp_pkg::PH_WAIT;
            end
            mfhp_pkg::PH_WAIT: begin
                if (pos == first_track_offset) begin
                    pcm = (b == cfg_opcode);
                    res.push_back(make_result(mfhp_pkg::KIND_MODE, '0, {16'h0, b}, pcm,
                                              pcm ? mfhp_pkg::TRACKS_PCM8
                                                  : mfhp_pkg::TRACKS_STD));
                    if ((far_mask & (pcm ? mfhp_pkg::USED_PCM8 : mfhp_pkg::USED_STD))
                            != 16'd0)
                        res.push_back(make_result(mfhp_pkg::KIND_ERROR, mfhp_pkg::ERR_FAR,
                                                  pos, 1'b0, '0));
                    ph = mfhp_pkg::PH_DONE;
                end
            end
            default: ;
        endcase
        if (lst && ph != mfhp_pkg::PH_DONE) begin
            res.push_back(make_result(mfhp_pkg::KIND_ERROR, mfhp_pkg::ERR_TRUNCATED, pos,
                                      1'b0, '0));
            ph = mfhp_pkg::PH_DONE;
        end
        if (stream_pos < mfhp_pkg::MAX24)
            stream_pos++;
        for (j = 0; j < res.size(); j++) begin
            r = res[j];
            r.last_of_run = (j == res.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string fname, input logic [23:0] want,
                               input logic [23:0] got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            mismatch_count++;
        end
    endtask

    // output beats are checked before the input beat of the same edge is predicted
    always @(posedge i_clk) begin : beat_monitor
        mfhp_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d index %0h value %0h",
                       o_kind, o_index, o_value);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 24'(want.kind), 24'(o_kind));
                check_field("index", 24'(want.index), 24'(o_index));
                check_field("value", want.value, o_value);
                check_field("flag", 24'(want.flag), 24'(o_flag));
                check_field("aux", 24'(want.aux), 24'(o_aux));
                check_field("last_of_run", 24'(want.last_of_run), 24'(o_last_of_run));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            parse_byte(i_data_byte, i_last_byte);
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : byte_driver
        t_file_byte fb;
        cycle_count++;
        if (cycle_count % 97 == 0)
            idle_mode = (idle_mode + 1) % 4;
        if (!i_in_valid || in_taken) begin
            if (file_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct[idle_mode]) begin
                fb = file_bytes.pop_front();
                i_in_valid <= 1'b1;
                i_data_byte <= fb.data;
                i_last_byte <= fb.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct[idle_mode]);
    end

    task automatic push_byte(input logic [7:0] b, input logic lst);
        t_file_byte fb;
        fb.data = b;
        fb.last = lst || (byte_count == trunc_at);
        file_bytes.push_back(fb);
        byte_count++;
    endtask

    // holds off until the parser has nothing in flight
    task automatic wait_idle();
        while (file_bytes.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_sel == mfhp_pkg::REG_FILE_LENGTH)
            cfg_file_length = data[23:0];
        else
            cfg_opcode = data[7:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial begin : stimulus
        int          scenario;
        int          title_len;
        int          name_kind;
        int          name_len;
        int          gap;
        int          base;
        int          i;
        int          k;
        logic        add_sfx;
        logic [7:0]  b;
        logic [7:0]  prev1;
        logic [7:0]  prev2;
        logic [15:0] word;
        logic [15:0] voice_word;
        logic [15:0] track0_word;
        logic [23:0] fl;
        logic [7:0]  opcode_sel;

        // most runs reach the mode byte; the rest end on one of the error paths
        scenario = int'($urandom_range(0, 9));
        if (scenario == 6)
            trunc_at = int'($urandom_range(3, 600));
        else
            trunc_at = -1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(mfhp_pkg::REG_FILE_LENGTH, $urandom);
        write_reg(mfhp_pkg::REG_PCM8_OPCODE, $urandom);

        // title: edge bytes and CR LF pairs not followed by EOF first, then random text
        title_len = int'($urandom_range(460, 660));
        prev1 = '0;
        prev2 = '0;
        for (i = 0; i < title_len; i++) begin
            case (i)
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h0D;
                3: b = 8'h0A;
                4: b = 8'h0D;
                5: b = 8'h0D;
                6: b = 8'h0A;
                7: b = 8'h41;
                8: b = 8'h80;
                9: b = 8'h7F;
                10: b = mfhp_pkg::TITLE_EOF;
                11: b = 8'h55;
                12: b = 8'hAA;
                default: begin
                    if ($urandom_range(0, 7) == 0)
                        b = (prev1 == 8'h0D) ? 8'h0A : 8'h0D;
                    else
                        b = 8'($urandom);
                end
            endcase
            if ({prev2, prev1} == mfhp_pkg::TITLE_CRLF && b == mfhp_pkg::TITLE_EOF)
                b = 8'h1B;
            push_byte(b, 1'b0);
            prev2 = prev1;
            prev1 = b;
        end
        push_byte(mfhp_pkg::TITLE_CRLF[15:8], 1'b0);
        push_byte(mfhp_pkg::TITLE_CRLF[7:0], 1'b0);
        push_byte(mfhp_pkg::TITLE_EOF, 1'b0);
        wait_idle();
        write_reg(mfhp_pkg::REG_PCM8_OPCODE, 32'h0);

        // sample-file name: empty, short with suffix, long (60 to 90 bytes), or short plain
        name_kind = int'($urandom_range(0, 3));
        add_sfx = 1'b0;
        case (name_kind)
            0: name_len = 0;
            1: begin
                name_len = int'($urandom_range(0, 8));
                add_sfx = 1'b1;
            end
            2: begin
                name_len = int'($urandom_range(60, 90));
                add_sfx = 1'($urandom_range(0, 1));
            end
            default: name_len = int'($urandom_range(1, 12));
        endcase
        for (i = 0; i < name_len; i++)
            push_byte(8'($urandom_range(1, 255)), 1'b0);
        if (add_sfx) begin
            for (k = 0; k < 4; k++) begin
                b = mfhp_pkg::PDX_SUFFIX[31 - 8 * k -: 8];
                if (k != 0 && $urandom_range(0, 1) != 0)
                    b = b - 8'h20;
                push_byte(b, 1'b0);
            end
        end
        push_byte(mfhp_pkg::NAME_END, 1'b0);
        base = byte_count;

        gap = int'($urandom_range(0, 150));
        track0_word = (scenario == 9) ? 16'($urandom_range(0, 33)) : 16'(34 + gap);
        voice_word = (scenario == 8) ? 16'($urandom_range(0, 33 + gap))
                                     : 16'($urandom_range(0, 65535));
        if (scenario == 7)
            fl = '0;
        else if (scenario == 8)
            fl = 24'(base + 33 + gap);
        else
            fl = mfhp_pkg::MAX24;
        wait_idle();
        write_reg(mfhp_pkg::REG_FILE_LENGTH, {8'h0, fl});
        write_reg(mfhp_pkg::REG_PCM8_OPCODE, 32'hFF);

        push_byte(voice_word[15:8], 1'b0);
        push_byte(voice_word[7:0], 1'b0);
        push_byte(track0_word[15:8], 1'b0);
        push_byte(track0_word[7:0], 1'b0);
        wait_idle();
        if ($urandom_range(0, 1) != 0)
            fl = mfhp_pkg::MAX24;
        else
            fl = 24'(base + int'($urandom_range(34, 65535)));
        write_reg(mfhp_pkg::REG_FILE_LENGTH, {8'h0, fl});

        for (i = 1; i <= 8; i++) begin
            word = 16'($urandom);
            push_byte(word[15:8], 1'b0);
            push_byte(word[7:0], 1'b0);
        end
        wait_idle();
        // a zero bound marks the upper tracks far, which only matters in sixteen-track mode
        if ($urandom_range(0, 1) != 0)
            fl = 24'h0;
        else
            fl = 24'(base + int'($urandom_range(0, 65535)));
        write_reg(mfhp_pkg::REG_FILE_LENGTH, {8'h0, fl});

        for (i = 9; i <= 15; i++) begin
            word = 16'($urandom);
            push_byte(word[15:8], 1'b0);
            push_byte(word[7:0], 1'b0);
        end
        wait_idle();
        case ($urandom_range(0, 2))
            0: opcode_sel = 8'h00;
            1: opcode_sel = 8'hFF;
            default: opcode_sel = 8'($urandom);
        endcase
        write_reg(mfhp_pkg::REG_PCM8_OPCODE, {24'h0, opcode_sel});

        for (i = 0; i < gap; i++)
            push_byte(8'($urandom), 1'b0);
        push_byte(($urandom_range(0, 1) != 0) ? opcode_sel : 8'($urandom),
                  1'($urandom_range(0, 1)));
        // bytes after the parse has finished are taken and give nothing
        for (i = 0; i < 5; i++)
            push_byte(8'($urandom), 1'($urandom_range(0, 1)));

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
